// ===== src/devicetree_struct_tokenizer_defines.svh =====
// assertion macros shared by the tokenizer rtl
`ifndef DEVICETREE_STRUCT_TOKENIZER_DEFINES_SVH
`define DEVICETREE_STRUCT_TOKENIZER_DEFINES_SVH

// checked on every rising clock edge outside reset
`define DTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every rising clock edge, reset included
`define DTS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== src/dts_pkg.sv =====
`timescale 1ns / 1ps

package dts_pkg;

  // block limits
  localparam int unsigned MAX_DEPTH   = 64;
  localparam int unsigned OFFSET_BITS = 24;

  localparam int unsigned DepthW = 7;
  localparam int unsigned LeftW  = 30;
  localparam int unsigned PosW   = 22;
  localparam int unsigned EoffW  = 24;

  // end offset keeps at most OFFSET_BITS bits
  localparam logic [EoffW-1:0] OffsetMask = (OFFSET_BITS >= EoffW) ?
      {EoffW{1'b1}} : EoffW'((64'd1 << OFFSET_BITS) - 64'd1);

  // structure block tag values
  localparam logic [31:0] TagBeginNode = 32'd1;
  localparam logic [31:0] TagEndNode   = 32'd2;
  localparam logic [31:0] TagProp      = 32'd3;
  localparam logic [31:0] TagNop       = 32'd4;
  localparam logic [31:0] TagEnd       = 32'd9;

  typedef enum logic [3:0] {
    CLS_BEGIN     = 4'd0,
    CLS_NAME      = 4'd1,
    CLS_END_NODE  = 4'd2,
    CLS_PROP      = 4'd3,
    CLS_LEN       = 4'd4,
    CLS_NAME_OFF  = 4'd5,
    CLS_DATA      = 4'd6,
    CLS_NOP       = 4'd7,
    CLS_END       = 4'd8,
    CLS_UNK_END   = 4'd9,
    CLS_AFTER_END = 4'd10
  } word_class_e;

  typedef enum logic [2:0] {
    MODE_TAG         = 3'd0,
    MODE_NAME        = 3'd1,
    MODE_LEN         = 3'd2,
    MODE_NOFF_DATA   = 3'd3,
    MODE_DATA        = 3'd4,
    MODE_DONE        = 3'd5,
    MODE_NOFF_NODATA = 3'd6
  } parse_mode_e;

  typedef struct packed {
    logic [31:0] word;
    logic        first;
  } dts_in_t;

  typedef struct packed {
    word_class_e       word_class;
    logic [31:0]       payload;
    logic              run_last;
    logic [DepthW-1:0] depth;
    logic              depth_error;
    logic [EoffW-1:0]  end_offset;
  } dts_out_t;

  typedef struct packed {
    parse_mode_e       mode;
    logic [LeftW-1:0]  left;
    logic [DepthW-1:0] depth;
    logic [PosW-1:0]   pos;
  } dts_state_t;

  localparam dts_state_t StateReset = '{
    mode:  MODE_TAG,
    left:  '0,
    depth: '0,
    pos:   '0
  };

endpackage

// ===== src/dts_step.sv =====
`timescale 1ns / 1ps

module dts_step import dts_pkg::*; (
  input  dts_state_t state_i,
  input  dts_in_t    item_i,
  output dts_state_t state_o,
  output dts_out_t   result_o
);

  // a name run ends at the word holding a nul byte
  function automatic logic has_zero_byte(input logic [31:0] w);
    has_zero_byte = (w[31:24] == 8'h00) || (w[23:16] == 8'h00) ||
                    (w[15:8] == 8'h00) || (w[7:0] == 8'h00);
  endfunction

  dts_state_t       cur;
  dts_state_t       nxt;
  logic [32:0]      len_sum;
  logic [30:0]      len_words;
  logic [EoffW-1:0] eoff;

  // a first word restarts the parse before it is classified
  assign cur = item_i.first ? StateReset : state_i;

  // word count of the property data, minus one
  assign len_sum   = {1'b0, item_i.word} + 33'd3;
  assign len_words = len_sum[32:2] - 31'd1;

  // byte offset just past the current word
  assign eoff = ({cur.pos, 2'b00} + EoffW'(4)) & OffsetMask;

  // classify the word and update the parse state
  always_comb begin
    nxt     = cur;
    nxt.pos = cur.pos + PosW'(1);

    result_o             = '0;
    result_o.word_class  = CLS_AFTER_END;
    result_o.payload     = item_i.word;

    unique case (cur.mode)
      MODE_TAG: begin
        if (item_i.word == TagBeginNode) begin
          result_o.word_class = CLS_BEGIN;
          if (cur.depth >= DepthW'(MAX_DEPTH)) begin
            result_o.depth_error = 1'b1;
          end else begin
            nxt.depth = cur.depth + DepthW'(1);
          end
          nxt.mode = MODE_NAME;
        end else if (item_i.word == TagEndNode) begin
          result_o.word_class = CLS_END_NODE;
          if (cur.depth == '0) begin
            result_o.depth_error = 1'b1;
          end else begin
            nxt.depth = cur.depth - DepthW'(1);
          end
        end else if (item_i.word == TagProp) begin
          result_o.word_class = CLS_PROP;
          nxt.mode            = MODE_LEN;
        end else if (item_i.word == TagNop) begin
          result_o.word_class = CLS_NOP;
        end else begin
          // unknown tags close the block like the end tag
          result_o.word_class = (item_i.word == TagEnd) ? CLS_END : CLS_UNK_END;
          result_o.end_offset = eoff;
          nxt.mode            = MODE_DONE;
        end
      end
      MODE_NAME: begin
        result_o.word_class = CLS_NAME;
        if (has_zero_byte(item_i.word)) begin
          result_o.run_last = 1'b1;
          nxt.mode          = MODE_TAG;
        end
      end
      MODE_LEN: begin
        result_o.word_class = CLS_LEN;
        if (item_i.word == '0) begin
          nxt.mode = MODE_NOFF_NODATA;
          nxt.left = '0;
        end else begin
          nxt.mode = MODE_NOFF_DATA;
          nxt.left = len_words[LeftW-1:0];
        end
      end
      MODE_NOFF_DATA: begin
        result_o.word_class = CLS_NAME_OFF;
        nxt.mode            = MODE_DATA;
      end
      MODE_NOFF_NODATA: begin
        result_o.word_class = CLS_NAME_OFF;
        nxt.mode            = MODE_TAG;
      end
      MODE_DATA: begin
        result_o.word_class = CLS_DATA;
        if (cur.left == '0) begin
          result_o.run_last = 1'b1;
          nxt.mode          = MODE_TAG;
        end else begin
          nxt.left = cur.left - LeftW'(1);
        end
      end
      default: begin
        // past the end tag, or an unused mode code
        result_o.word_class = CLS_AFTER_END;
        nxt.mode            = MODE_DONE;
      end
    endcase

    result_o.depth = nxt.depth;
    state_o        = nxt;
  end

endmodule

// ===== src/devicetree_struct_tokenizer.sv =====
`timescale 1ns / 1ps

// Devicetree structure block tokenizer. Takes one 32-bit structure word per
// beat (already in host order) and returns one result beat per word: its
// class, the word itself, a flag on the last word of a name or of property
// data, the node depth after the word with a depth error flag, and on the end
// tag (or an unknown tag) the byte offset just past it. Set first on the
// opening word of a block to restart the parse. Each word passes an input
// register, the combinational classification logic and an output register,
// so the result comes from the output register once the word leaves the
// input register, and the block takes one word every cycle while results
// are taken; the only loop is the parse state update. Backpressure from the
// output reaches the input ready in the same cycle.
`include "devicetree_struct_tokenizer_defines.svh"

module devicetree_struct_tokenizer import dts_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dts_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output dts_out_t out_data_o
);

  logic       s1_valid_q;
  dts_in_t    s1_q;
  logic       out_valid_q;
  dts_out_t   out_q;
  dts_state_t state_q;
  dts_state_t state_d;
  dts_out_t   result;
  logic       out_free;
  logic       advance;

  // handshake between the two register stages
  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_q <= in_data_i;
    end
  end

  // classification of the registered word
  dts_step u_step (
    .state_i  (state_q),
    .item_i   (s1_q),
    .state_o  (state_d),
    .result_o (result)
  );

  // parse state moves on with each word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  `DTS_ASSERT(a_depth_bound, state_q.depth <= DepthW'(MAX_DEPTH), "node depth beyond maximum")
  `DTS_ASSERT(a_advance_shows, advance |=> out_valid_o, "classified word not presented")
  `DTS_ASSERT(a_stall_cause, !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i),
              "input stalled without output backpressure")
  `DTS_ASSERT(a_offset_only_end, (out_valid_o && out_data_o.word_class != CLS_END &&
              out_data_o.word_class != CLS_UNK_END) |-> (out_data_o.end_offset == '0),
              "end offset on a non-end beat")

endmodule

// ===== sim/tb_devicetree_struct_tokenizer.sv =====
`timescale 1ns / 1ps

// keeps its own copy of the parse state, works out the expected result beat
// for every accepted word and checks result beats against them in order
class dts_token_scoreboard;

  dts_pkg::parse_mode_e                 mode;
  logic [dts_pkg::LeftW-1:0]            words_left;
  logic [dts_pkg::DepthW-1:0]           depth;
  logic [dts_pkg::PosW-1:0]             pos;
  dts_pkg::dts_out_t                    expected_tokens[$];
  int unsigned                          failures;

  function new();
    mode       = dts_pkg::MODE_TAG;
    words_left = '0;
    depth      = '0;
    pos        = '0;
    failures   = 0;
  endfunction

  function bit has_nul(logic [31:0] w);
    bit nul;
    nul = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (w[8*k +: 8] == 8'h00) nul = 1'b1;
    end
    return nul;
  endfunction

  // expected result for one word, advancing the parse state
  function dts_pkg::dts_out_t classify_word(dts_pkg::dts_in_t b);
    dts_pkg::dts_out_t r;
    logic [32:0]       len_words;
    r.word_class  = dts_pkg::CLS_AFTER_END;
    r.payload     = b.word;
    r.run_last    = 1'b0;
    r.depth_error = 1'b0;
    r.end_offset  = '0;
    // restart on the opening word of a block
    if (b.first) begin
      mode       = dts_pkg::MODE_TAG;
      words_left = '0;
      depth      = '0;
      pos        = '0;
    end
    case (mode)
      dts_pkg::MODE_TAG: begin
        if (b.word == dts_pkg::TagBeginNode) begin
          r.word_class = dts_pkg::CLS_BEGIN;
          if (depth >= dts_pkg::MAX_DEPTH) r.depth_error = 1'b1;
          else depth = depth + 1'b1;
          mode = dts_pkg::MODE_NAME;
        end else if (b.word == dts_pkg::TagEndNode) begin
          r.word_class = dts_pkg::CLS_END_NODE;
          if (depth == '0) r.depth_error = 1'b1;
          else depth = depth - 1'b1;
        end else if (b.word == dts_pkg::TagProp) begin
          r.word_class = dts_pkg::CLS_PROP;
          mode = dts_pkg::MODE_LEN;
        end else if (b.word == dts_pkg::TagNop) begin
          r.word_class = dts_pkg::CLS_NOP;
        end else begin
          // end tag, and any unknown tag ends the block too
          r.word_class = (b.word == dts_pkg::TagEnd) ? dts_pkg::CLS_END :
                                                       dts_pkg::CLS_UNK_END;
          r.end_offset = dts_pkg::EoffW'(({10'd0, pos} + 32'd1) << 2) &
                         dts_pkg::OffsetMask;
          mode = dts_pkg::MODE_DONE;
        end
      end
      dts_pkg::MODE_NAME: begin
        r.word_class = dts_pkg::CLS_NAME;
        if (has_nul(b.word)) begin
          r.run_last = 1'b1;
          mode = dts_pkg::MODE_TAG;
        end
      end
      dts_pkg::MODE_LEN: begin
        r.word_class = dts_pkg::CLS_LEN;
        if (b.word == 32'd0) begin
          words_left = '0;
          mode = dts_pkg::MODE_NOFF_NODATA;
        end else begin
          // whole words of data, minus one
          len_words  = ({1'b0, b.word} + 33'd3) >> 2;
          words_left = dts_pkg::LeftW'(len_words - 33'd1);
          mode = dts_pkg::MODE_NOFF_DATA;
        end
      end
      dts_pkg::MODE_NOFF_DATA: begin
        r.word_class = dts_pkg::CLS_NAME_OFF;
        mode = dts_pkg::MODE_DATA;
      end
      dts_pkg::MODE_NOFF_NODATA: begin
        r.word_class = dts_pkg::CLS_NAME_OFF;
        mode = dts_pkg::MODE_TAG;
      end
      dts_pkg::MODE_DATA: begin
        r.word_class = dts_pkg::CLS_DATA;
        if (words_left == '0) begin
          r.run_last = 1'b1;
          mode = dts_pkg::MODE_TAG;
        end else begin
          words_left = words_left - 1'b1;
        end
      end
      default: begin
        r.word_class = dts_pkg::CLS_AFTER_END;
        mode = dts_pkg::MODE_DONE;
      end
    endcase
    pos     = pos + 1'b1;
    r.depth = depth;
    return r;
  endfunction

  function void note_word(dts_pkg::dts_in_t b);
    expected_tokens.push_back(classify_word(b));
  endfunction

  function void check_token(dts_pkg::dts_out_t got);
    dts_pkg::dts_out_t want;
    if (expected_tokens.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("unexpected result beat: class %0d payload %h", got.word_class, got.payload);
      return;
    end
    want = expected_tokens.pop_front();
    if (got.word_class !== want.word_class || got.payload !== want.payload ||
        got.run_last !== want.run_last || got.depth !== want.depth ||
        got.depth_error !== want.depth_error || got.end_offset !== want.end_offset) begin
      failures++;
      if (failures <= 10) begin
        $write("mismatch on %h: class %0d/%0d last %0d/%0d depth %0d/%0d ",
               want.payload, want.word_class, got.word_class, want.run_last,
               got.run_last, want.depth, got.depth);
        $display("err %0d/%0d eoff %h/%h payload %h (exp/act)",
                 want.depth_error, got.depth_error, want.end_offset, got.end_offset,
                 got.payload);
      end
    end
  endfunction

  function int unsigned pending();
    return expected_tokens.size();
  endfunction

endclass

module tb_devicetree_struct_tokenizer;
  import dts_pkg::*;

  localparam int unsigned RandomWords = 1900;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid;
  logic     in_ready;
  dts_in_t  in_beat;
  logic     out_valid;
  logic     out_ready;
  dts_out_t out_beat;

  dts_token_scoreboard tokens = new();

  dts_in_t     word_plan[$];
  bit          block_start;
  int unsigned tx_burst;
  int unsigned rx_burst;

  devicetree_struct_tokenizer i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_beat),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_beat)
  );

  // clock and reset
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // run limit
  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // wait cycles for one beat, with stretches of back-to-back beats
  function automatic int unsigned draw_gap(inout int unsigned burst);
    if (burst != 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) burst = $urandom_range(20, 80);
    return $urandom_range(0, 9);
  endfunction

  // stimulus plan building
  function automatic void add_word(logic [31:0] w);
    dts_in_t b;
    b.word      = w;
    b.first     = block_start;
    block_start = 1'b0;
    word_plan.push_back(b);
  endfunction

  function automatic logic [31:0] nul_free_word();
    logic [31:0] w;
    for (int k = 0; k < 4; k++) w[8*k +: 8] = 8'($urandom_range(1, 255));
    return w;
  endfunction

  // node name: some full words, then one holding at least one nul byte
  function automatic void add_name(int unsigned max_full);
    logic [31:0] w;
    repeat ($urandom_range(0, max_full)) add_word(nul_free_word());
    w = $urandom;
    w[8*$urandom_range(0, 3) +: 8] = 8'h00;
    if ($urandom_range(0, 3) == 0) w[8*$urandom_range(0, 3) +: 8] = 8'h00;
    add_word(w);
  endfunction

  // property; returns 1 when the length is too large to finish the block
  function automatic bit add_prop();
    logic [31:0] len;
    logic [32:0] n_words;
    int unsigned sel;
    bit          broken;
    broken = 1'b0;
    sel = $urandom_range(0, 39);
    if (sel < 6)       len = 32'd0;
    else if (sel < 32) len = $urandom_range(1, 24);
    else if (sel < 38) len = $urandom_range(25, 80);
    else begin
      len    = $urandom | 32'h8000_0000;
      broken = 1'b1;
    end
    add_word(TagProp);
    add_word(len);
    add_word($urandom);
    n_words = ({1'b0, len} + 33'd3) >> 2;
    if (broken) n_words = 33'($urandom_range(0, 4));
    repeat (int'(n_words)) add_word($urandom);
    return broken;
  endfunction

  // nest past the depth limit, then unwind past zero
  function automatic void add_deep_nest();
    repeat (MAX_DEPTH + 2) begin
      add_word(TagBeginNode);
      add_name(0);
    end
    repeat (MAX_DEPTH + 3) add_word(TagEndNode);
  endfunction

  function automatic void add_block();
    int unsigned open_nodes;
    int unsigned r;
    open_nodes  = 0;
    block_start = 1'b1;
    if ($urandom_range(0, 24) == 0) add_deep_nest();
    repeat ($urandom_range(3, 40)) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        add_word(TagBeginNode);
        add_name(3);
        open_nodes++;
      end else if (r < 55) begin
        if (open_nodes != 0) begin
          add_word(TagEndNode);
          open_nodes--;
        end else begin
          add_word(TagNop);
        end
      end else if (r < 80) begin
        if (add_prop()) return;
      end else if (r < 88) begin
        add_word(TagNop);
      end else if (r < 92) begin
        // may underflow when no node is open
        add_word(TagEndNode);
        if (open_nodes != 0) open_nodes--;
      end else if (r < 97) begin
        add_word($urandom);
      end else begin
        // restart in the middle of a block
        block_start = 1'b1;
        add_word($urandom_range(0, 1) ? TagBeginNode : $urandom);
        open_nodes = 0;
      end
    end
    if ($urandom_range(0, 1)) repeat (open_nodes) add_word(TagEndNode);
    add_word(($urandom_range(0, 6) != 0) ? TagEnd : $urandom);
    repeat ($urandom_range(0, 3)) add_word($urandom);
  endfunction

  function automatic void add_directed();
    block_start = 1'b1;
    add_word(TagBeginNode);
    add_word(32'h4142_4300);
    add_word(TagEndNode);
    add_word(TagEndNode);        // end-node at depth zero
    add_word(TagNop);
    add_word(TagProp);
    add_word(32'd0);             // empty property
    add_word(32'hFFFF_FFFF);
    add_word(TagProp);
    add_word(32'd5);
    add_word(32'd0);
    add_word(32'hFFFF_FFFF);
    add_word(32'h0000_0000);
    add_word(TagBeginNode);
    add_word(32'hFF00_FFFF);
    add_word(32'h00FF_FFFF);     // extra name words are tags again
    add_word(TagProp);
    add_word(32'hFFFF_FFFF);     // largest length, parsed after the end
    add_word(32'h1234_5678);
    add_word(32'hAAAA_AAAA);
    add_word(32'h5555_5555);
    block_start = 1'b1;
    add_word(TagEnd);
    add_word(32'hFFFF_FFFF);     // words after the end
    add_word(TagProp);
    block_start = 1'b1;
    add_word(32'hFFFF_FFFF);     // unknown tag
    block_start = 1'b1;
    add_word(32'd0);
    add_word(TagBeginNode);
  endfunction

  // one input beat, entered and left at a falling edge
  task automatic drive_word(dts_in_t b);
    int unsigned gap;
    gap = draw_gap(tx_burst);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_beat  = b;
    in_valid = 1'b1;
    do @(posedge clk_i); while (!in_ready);
    tokens.note_word(b);
    @(negedge clk_i);
  endtask

  // result side ready pattern
  initial begin
    int unsigned stall;
    out_ready = 1'b0;
    rx_burst  = 0;
    @(posedge rst_ni);
    forever begin
      stall = draw_gap(rx_burst);
      if (stall != 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready = 1'b1;
      do @(posedge clk_i); while (!out_valid);
      @(negedge clk_i);
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) tokens.check_token(out_beat);
  end

  // stimulus and end of run
  initial begin
    int unsigned settle;
    in_valid = 1'b0;
    in_beat  = '0;
    tx_burst = 0;
    add_directed();
    while (word_plan.size() < RandomWords + 25) add_block();
    @(posedge rst_ni);
    foreach (word_plan[i]) drive_word(word_plan[i]);
    in_valid = 1'b0;
    while (tokens.pending() != 0) @(posedge clk_i);
    settle = 16;
    repeat (settle) @(posedge clk_i);
    if (tokens.failures == 0 && tokens.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
